### src/i2c_sensor_register_file_core_defines.svh
// Assertion macros for the I2C sensor register file core.
// Used by the top level only; the including module provides clk and rst_n.
`ifndef I2C_SENSOR_REGISTER_FILE_CORE_DEFINES_SVH
`define I2C_SENSOR_REGISTER_FILE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define ISRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ISRF_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ISRF_ASSERT(lbl, prop, msg)
`define ISRF_NEVER(lbl, cond, msg)
`endif

`endif

### src/isrf_pkg.sv
// Shared types, constants and address decode for the I2C sensor register file.
// No dependencies; used by isrf_bank and i2c_sensor_register_file_core.
`default_nettype none

package isrf_pkg;

  localparam int REGISTER_COUNT = 55;
  localparam int PtrW = 8;
  localparam int IdxW = 6;
  localparam int WrCount = 8;
  localparam int SlotW = 3;

  typedef enum logic [1:0] {
    CMD_SEND    = 2'd0,
    CMD_RECEIVE = 2'd1,
    CMD_FINISH  = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  localparam logic [7:0] FAULT_BYTE = 8'hFF;

  // register addresses
  localparam logic [IdxW-1:0] ADDR_CYC_FIRST = 6'h04;
  localparam logic [IdxW-1:0] ADDR_CYC_LAST  = 6'h09;
  localparam logic [IdxW-1:0] ADDR_TIMER     = 6'h0B;
  localparam logic [IdxW-1:0] ADDR_CTRL      = 6'h33;
  localparam logic [IdxW-1:0] ADDR_STATUS    = 6'h34;
  localparam logic [IdxW-1:0] ADDR_HANDSHAKE = 6'h35;

  // writable slots
  localparam logic [SlotW-1:0] SLOT_CTRL      = 3'd6;
  localparam logic [SlotW-1:0] SLOT_HANDSHAKE = 3'd7;

  localparam logic [7:0] CYC_DEFAULT       = 8'hC8;
  localparam logic [7:0] TIMER_DEFAULT     = 8'h96;
  localparam logic [7:0] STATUS_DEFAULT    = 8'h80;
  localparam logic [7:0] HANDSHAKE_DEFAULT = 8'h1B;

  typedef struct packed {
    logic              en;
    logic [SlotW-1:0]  slot;
    logic [7:0]        data;
  } bank_wr_t;

  function automatic logic is_writable(input logic [IdxW-1:0] idx);
    return (idx >= ADDR_CYC_FIRST && idx <= ADDR_CYC_LAST) ||
           idx == ADDR_CTRL || idx == ADDR_HANDSHAKE;
  endfunction

  // Map a writable address onto its storage slot
  function automatic logic [SlotW-1:0] slot_of(input logic [IdxW-1:0] idx);
    logic [IdxW-1:0] off;
    off = idx - ADDR_CYC_FIRST;
    if (idx == ADDR_CTRL) begin
      return SLOT_CTRL;
    end else if (idx == ADDR_HANDSHAKE) begin
      return SLOT_HANDSHAKE;
    end else begin
      return off[SlotW-1:0];
    end
  endfunction

  // Reset value of a writable slot: odd cycle-count slots hold the default count
  function automatic logic [7:0] wr_reset(input logic [SlotW-1:0] slot);
    logic [7:0] val;
    case (slot)
      3'd1, 3'd3, 3'd5: val = CYC_DEFAULT;
      SLOT_HANDSHAKE:   val = HANDSHAKE_DEFAULT;
      default:          val = 8'h00;
    endcase
    return val;
  endfunction

  // Fixed contents of the read-only registers
  function automatic logic [7:0] rom_byte(input logic [IdxW-1:0] idx);
    logic [7:0] val;
    case (idx)
      ADDR_TIMER:  val = TIMER_DEFAULT;
      ADDR_STATUS: val = STATUS_DEFAULT;
      default:     val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

### src/i2c_sensor_register_file_core.sv
// Usage notes:
// Slave-side register file of an I2C magnetometer with an auto-incrementing
// byte pointer. One bus event per input transaction: in_command selects send,
// receive, finish or no-op, in_write_data carries the sent byte.
// Every input transaction yields exactly one result transaction on out_*:
// out_read_data holds the addressed byte for a receive (0xFF with
// out_read_fault set on an invalid or out-of-range pointer), zero otherwise.
// Timing: an accepted item is registered in the input register, its result
// is registered in the output register when that register can take it, and
// out_valid then rises. Pointer and register updates happen in that single
// decode step, so one item per cycle is sustained while out_ready stays high.
// When out_ready is low the result holds, the input register fills and
// in_ready falls; nothing is dropped.
// Reset (rst_n low, synchronous): pipeline empties, pointer becomes invalid,
// registers return to their defaults in the same cycle.
// Depends on isrf_pkg, isrf_bank and the defines header.
`default_nettype none
`include "i2c_sensor_register_file_core_defines.svh"

module i2c_sensor_register_file_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_command,
  input  wire logic [7:0] in_write_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_read_data,
  output logic            out_read_fault
);

  logic                           s1_valid_r;
  isrf_pkg::cmd_t                 s1_cmd_r;
  logic [7:0]                     s1_data_r;
  logic                           out_valid_r;
  logic [7:0]                     out_read_data_r;
  logic                           out_read_fault_r;
  logic [isrf_pkg::PtrW-1:0]      ptr_r;
  logic [isrf_pkg::PtrW-1:0]      ptr_nxt;
  logic                           ptr_valid_r;
  logic                           ptr_valid_nxt;
  logic [7:0]                     rdata_nxt;
  logic                           fault_nxt;
  logic                           s1_fire;
  logic                           ptr_in_range;
  logic [isrf_pkg::IdxW-1:0]      idx;
  logic [7:0]                     bank_rd;
  isrf_pkg::bank_wr_t             bank_wr;

  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  assign ptr_in_range = ptr_r < isrf_pkg::PtrW'(isrf_pkg::REGISTER_COUNT);
  assign idx          = ptr_r[isrf_pkg::IdxW-1:0];

  isrf_bank u_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (bank_wr),
    .rd_idx  (idx),
    .rd_data (bank_rd)
  );

  always_comb begin
    ptr_nxt       = ptr_r;
    ptr_valid_nxt = ptr_valid_r;
    rdata_nxt     = 8'h00;
    fault_nxt     = 1'b0;
    bank_wr.en    = 1'b0;
    bank_wr.slot  = isrf_pkg::slot_of(idx);
    bank_wr.data  = s1_data_r;
    case (s1_cmd_r)
      isrf_pkg::CMD_SEND: begin
        if (!ptr_valid_r) begin
          ptr_nxt       = s1_data_r;
          ptr_valid_nxt = 1'b1;
        end else if (ptr_in_range) begin
          // read-only targets drop the data but still advance
          bank_wr.en = s1_fire && isrf_pkg::is_writable(idx);
          ptr_nxt    = ptr_r + isrf_pkg::PtrW'(1);
        end
      end
      isrf_pkg::CMD_RECEIVE: begin
        if (ptr_valid_r && ptr_in_range) begin
          rdata_nxt = bank_rd;
          ptr_nxt   = ptr_r + isrf_pkg::PtrW'(1);
        end else begin
          rdata_nxt = isrf_pkg::FAULT_BYTE;
          fault_nxt = 1'b1;
        end
      end
      isrf_pkg::CMD_FINISH: begin
        ptr_valid_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ptr_r       <= '0;
      ptr_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
        ptr_r       <= ptr_nxt;
        ptr_valid_r <= ptr_valid_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd_r  <= isrf_pkg::cmd_t'(in_command);
      s1_data_r <= in_write_data;
    end
    if (s1_fire) begin
      out_read_data_r  <= rdata_nxt;
      out_read_fault_r <= fault_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = out_read_data_r;
  assign out_read_fault = out_read_fault_r;

  `ISRF_ASSERT(a_fault_byte,
    out_valid_r && out_read_fault_r |-> out_read_data_r == isrf_pkg::FAULT_BYTE,
    "fault result without 0xFF data")
  `ISRF_ASSERT(a_finish_clears,
    s1_fire && s1_cmd_r == isrf_pkg::CMD_FINISH |=> !ptr_valid_r,
    "finish did not invalidate pointer")
  `ISRF_ASSERT(a_rx_advance,
    s1_fire && s1_cmd_r == isrf_pkg::CMD_RECEIVE && ptr_valid_r && ptr_in_range
    |=> ptr_r == isrf_pkg::PtrW'($past(ptr_r) + isrf_pkg::PtrW'(1)),
    "receive did not advance pointer")
  `ISRF_NEVER(a_wr_invalid, bank_wr.en && !ptr_valid_r, "register write with invalid pointer")

endmodule

`default_nettype wire

### src/isrf_bank.sv
// Register bank: flops for the writable registers, constant decode for the rest.
// Depends on isrf_pkg.
`default_nettype none

module isrf_bank (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire isrf_pkg::bank_wr_t            wr,
  input  wire logic [isrf_pkg::IdxW-1:0]     rd_idx,
  output logic      [7:0]                    rd_data
);

  logic [7:0] bank_r [isrf_pkg::WrCount];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < isrf_pkg::WrCount; i++) begin
        bank_r[i] <= isrf_pkg::wr_reset(isrf_pkg::SlotW'(i));
      end
    end else if (wr.en) begin
      bank_r[wr.slot] <= wr.data;
    end
  end

  always_comb begin
    if (isrf_pkg::is_writable(rd_idx)) begin
      rd_data = bank_r[isrf_pkg::slot_of(rd_idx)];
    end else begin
      rd_data = isrf_pkg::rom_byte(rd_idx);
    end
  end

endmodule

`default_nettype wire
